/* rtl/sbeta_pkg.sv */
// Shared types and constants for the SnakeBeta activation block
package sbeta_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CH_W     = 10;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = 40;
    localparam int PHASE_W  = 48;
    localparam int FRAC_W   = 16;
    localparam int SQ_W     = 31;
    localparam int TERM_W   = 22;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] ONE_Q30    = 64'd1073741824;

    localparam logic signed [SAMPLE_W:0] RES_MAX = 25'sd8388607;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic [CH_W-1:0]            ch;
        logic [COEF_W-1:0]          alpha;
        logic [COEF_W-1:0]          inv_beta;
    } t_work;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic [CH_W-1:0]            ch;
        logic [COEF_W-1:0]          inv_beta;
    } t_side;

endpackage

/* rtl/sbeta_front.sv */
// Front end: accepts items, writes or reads the per-channel coefficient memory
module sbeta_front
    import sbeta_pkg::*;
#(
    parameter int NUM_CHANNELS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [CH_W-1:0]            i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [COEF_W-1:0]          i_alpha_value,
    input  logic [COEF_W-1:0]          i_inv_beta_value,
    output logic                       o_push,
    output t_work                      o_work,
    input  logic                       i_q_full
);

    localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CMP_W = ($clog2(NUM_CHANNELS + 1) > CH_W) ? $clog2(NUM_CHANNELS + 1) : CH_W;

    logic [2*COEF_W-1:0]        r_coef_mem [0:NUM_CHANNELS-1];
    logic [2*COEF_W-1:0]        r_rd;
    logic                       r_fv;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [CH_W-1:0]            r_ch;
    logic                       r_in_range;

    logic          w_acc;
    logic          w_in_range;
    logic [AW-1:0] w_addr;

    assign w_in_range = CMP_W'(i_channel) < CMP_W'(NUM_CHANNELS);
    assign w_addr     = AW'(i_channel);
    assign o_push     = r_fv && !i_q_full;
    assign o_stall    = r_fv && i_q_full;
    assign w_acc      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req_type == REQ_LOAD) && w_in_range) begin
            r_coef_mem[w_addr] <= {i_alpha_value, i_inv_beta_value};
        end
        if (w_acc && (i_req_type == REQ_SAMPLE)) begin
            r_rd       <= r_coef_mem[w_addr];
            r_x        <= i_sample;
            r_ch       <= i_channel;
            r_in_range <= w_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_acc) begin
            r_fv <= (i_req_type == REQ_SAMPLE);
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_comb begin
        o_work.x        = r_x;
        o_work.ch       = r_ch;
        o_work.alpha    = r_in_range ? r_rd[2*COEF_W-1:COEF_W] : '0;
        o_work.inv_beta = r_in_range ? r_rd[COEF_W-1:0] : '0;
    end

endmodule

/* rtl/sbeta_fifo.sv */
// Short queue between the front end and the arithmetic pipeline
module sbeta_fifo
    import sbeta_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_head,
    output logic  o_empty
);

    t_work             r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

/* rtl/sbeta_back.sv */
// Arithmetic pipeline: phase, sin^2 lookup with interpolation, scale, add and saturate
module sbeta_back
    import sbeta_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_work                      i_head,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_result,
    output logic [CH_W-1:0]            o_result_channel
);

    localparam int NS = 10;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = PHASE_W + IW;

    logic [SQ_W-1:0] sq_rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] KF =
            64'((2 * k > SINE_TABLE_DEPTH) ? (SINE_TABLE_DEPTH - k) : k);
        localparam logic [63:0] A  = (KF * PI_Q30) / 64'(SINE_TABLE_DEPTH);
        localparam logic [63:0] A2 = (A * A) >> 30;
        localparam logic [63:0] P1 = ONE_Q30 - A2 / 64'd110;
        localparam logic [63:0] P2 = ONE_Q30 - ((A2 * P1) >> 30) / 64'd72;
        localparam logic [63:0] P3 = ONE_Q30 - ((A2 * P2) >> 30) / 64'd42;
        localparam logic [63:0] P4 = ONE_Q30 - ((A2 * P3) >> 30) / 64'd20;
        localparam logic [63:0] P5 = ONE_Q30 - ((A2 * P4) >> 30) / 64'd6;
        localparam logic [63:0] S  = (A * P5) >> 30;
        localparam logic [63:0] SC = (S > ONE_Q30) ? ONE_Q30 : S;
        localparam logic [63:0] S2 = (SC * SC) >> 30;
        assign sq_rom[k] = SQ_W'(S2);
    end

    logic                       w_adv;
    logic                       w_pop;

    logic [NS-1:0]              r_vld;
    t_side [NS-1:0]             r_side;
    t_side                      n_side0;

    logic signed [PROD_W:0]     n_tfull;
    logic signed [PROD_W-1:0]   r_t;
    logic [50:0]                n_lo;
    logic [50:0]                r_lo;
    logic signed [51:0]         n_hi;
    logic [39:0]                r_hi;
    logic [59:0]                n_u;
    logic [PHASE_W-1:0]         r_g;
    logic [PW-1:0]              n_p;
    logic [IW-1:0]              r_idx;
    logic [FRAC_W-1:0]          r_r4;
    logic [SQ_W-1:0]            r_t0;
    logic [SQ_W-1:0]            r_t1;
    logic [FRAC_W-1:0]          r_r5;
    logic                       n_up;
    logic [SQ_W-1:0]            n_d;
    logic                       r_up6;
    logic [SQ_W-1:0]            r_d;
    logic [SQ_W-1:0]            r_t06;
    logic [FRAC_W-1:0]          r_r6;
    logic [SQ_W+FRAC_W-1:0]     n_dr;
    logic                       r_up7;
    logic [SQ_W-1:0]            r_q;
    logic [SQ_W-1:0]            r_t07;
    logic [SQ_W-1:0]            n_v;
    logic [SQ_W-1:0]            r_v;
    logic [SQ_W+COEF_W-1:0]     n_m;
    logic [SQ_W+COEF_W-1:0]     r_m;
    logic [SQ_W+COEF_W:0]       n_rnd;
    logic [TERM_W-1:0]          r_term;
    logic signed [SAMPLE_W:0]   n_y;
    logic signed [SAMPLE_W-1:0] n_res;

    logic                       r_ov;
    logic signed [SAMPLE_W-1:0] r_res;
    logic [CH_W-1:0]            r_rch;

    assign w_adv   = !r_ov || !i_stall;
    assign w_pop   = w_adv && !i_q_empty;
    assign o_q_pop = w_pop;

    always_comb begin
        n_side0.x        = i_head.x;
        n_side0.ch       = i_head.ch;
        n_side0.inv_beta = i_head.inv_beta;

        n_tfull = i_head.x * $signed({1'b0, i_head.alpha});
        n_lo    = 51'(r_t[19:0]) * 51'(INV_PI_Q32);
        n_hi    = $signed(r_t[39:20]) * $signed({1'b0, INV_PI_Q32});
        n_u     = 60'(r_lo) + {r_hi, 20'b0};
        n_p     = PW'(r_g) * PW'(SINE_TABLE_DEPTH);

        n_up = (r_t1 >= r_t0);
        n_d  = n_up ? (r_t1 - r_t0) : (r_t0 - r_t1);
        n_dr = (SQ_W + FRAC_W)'(r_d) * (SQ_W + FRAC_W)'(r_r6);
        n_v  = r_up7 ? (r_t07 + r_q) : (r_t07 - r_q);
        n_m  = (SQ_W + COEF_W)'(r_side[7].inv_beta) * (SQ_W + COEF_W)'(r_v);
        n_rnd = (SQ_W + COEF_W + 1)'(r_m) + (SQ_W + COEF_W + 1)'(1 << 25);

        n_y = {r_side[9].x[SAMPLE_W-1], r_side[9].x}
              + $signed({3'b000, r_term});
        if (n_y > RES_MAX) begin
            n_res = RES_MAX[SAMPLE_W-1:0];
        end else begin
            n_res = n_y[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side <= {r_side[NS-2:0], n_side0};
            r_t    <= n_tfull[PROD_W-1:0];
            r_lo   <= n_lo;
            r_hi   <= n_hi[39:0];
            r_g    <= n_u[59:12];
            r_idx  <= n_p[PW-1:PHASE_W];
            r_r4   <= n_p[PHASE_W-1:PHASE_W-FRAC_W];
            r_t0   <= sq_rom[r_idx];
            r_t1   <= sq_rom[r_idx + IW'(1)];
            r_r5   <= r_r4;
            r_up6  <= n_up;
            r_d    <= n_d;
            r_t06  <= r_t0;
            r_r6   <= r_r5;
            r_up7  <= r_up6;
            r_q    <= n_dr[SQ_W+FRAC_W-1:FRAC_W];
            r_t07  <= r_t06;
            r_v    <= n_v;
            r_m    <= n_m;
            r_term <= n_rnd[SQ_W+COEF_W:26];
            r_res  <= n_res;
            r_rch  <= r_side[9].ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], w_pop};
            r_ov  <= r_vld[NS-1];
        end
    end

    assign o_valid          = r_ov;
    assign o_result         = r_res;
    assign o_result_channel = r_rch;

endmodule

/* rtl/snake_beta_activation.sv */
// Top level of the SnakeBeta activation block
//
// Computes y = x + inv_beta * sin^2(alpha * x) on signed Q8.16 samples, one item per
// clock cycle sustained while i_stall is low. A load item (req_type 0) writes a
// channel's alpha and reciprocal beta into the coefficient memory and yields no
// result; a sample item (req_type 1) yields one saturated result tagged with its
// channel. Each channel must be loaded before its first sample; a channel at or
// above NUM_CHANNELS passes the sample through unchanged. Throughput is one item per
// cycle while the output is not stalled, set by the single coefficient memory port
// in the front end and the fully pipelined arithmetic in the back end. A sample's
// result passes from the coefficient read into the four-entry queue, then through
// the arithmetic pipeline and the output register.
module snake_beta_activation
    import sbeta_pkg::*;
#(
    parameter int NUM_CHANNELS     = 1024,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [CH_W-1:0]            i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [COEF_W-1:0]          i_alpha_value,
    input  logic [COEF_W-1:0]          i_inv_beta_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_result,
    output logic [CH_W-1:0]            o_result_channel
);

    logic  w_push;
    t_work w_work;
    logic  w_q_full;
    logic  w_q_pop;
    t_work w_head;
    logic  w_q_empty;

    sbeta_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_channel       (i_channel),
        .i_sample        (i_sample),
        .i_alpha_value   (i_alpha_value),
        .i_inv_beta_value(i_inv_beta_value),
        .o_push          (w_push),
        .o_work          (w_work),
        .i_q_full        (w_q_full)
    );

    sbeta_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_work (w_work),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_head (w_head),
        .o_empty(w_q_empty)
    );

    sbeta_back #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_empty       (w_q_empty),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result        (o_result),
        .o_result_channel(o_result_channel)
    );

endmodule
